// File: rtl/rpwc_pkg.sv
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared constants, types and codes of the read pair window clustering unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpwc_pkg;

   localparam int MAX_PAIRS = 64;
   localparam int IDX_W     = $clog2(MAX_PAIRS);
   localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

   localparam int POS_W     = 32;
   localparam int LEN_W     = 16;
   localparam int WIN_W     = 20;
   localparam int MINP_W    = 7;
   localparam int MEMBER_W  = 7;
   localparam int SEED_W    = 6;
   localparam int CMP_W     = (CNT_W > MINP_W) ? CNT_W : MINP_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = WIN_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PAIRS      = 1'd1;

   localparam logic [WIN_W-1:0]  WINDOW_RESET    = 20'd1000;
   localparam logic [MINP_W-1:0] MIN_PAIRS_RESET = 7'd2;

   typedef struct packed {
      logic [POS_W-1:0] first_pos;
      logic [LEN_W-1:0] first_len;
      logic [POS_W-1:0] second_pos;
      logic [LEN_W-1:0] second_len;
   } pair_type;

   typedef struct packed {
      logic [POS_W-1:0]    start_one;
      logic [POS_W-1:0]    end_one;
      logic [POS_W-1:0]    start_two;
      logic [POS_W-1:0]    end_two;
      logic [MEMBER_W-1:0] member_count;
      logic [SEED_W-1:0]   seed_index;
      logic                last_cluster;
   } result_type;

   typedef struct packed {
      logic [POS_W-1:0] start_one;
      logic [POS_W-1:0] end_one;
      logic [POS_W-1:0] start_two;
      logic [POS_W-1:0] end_two;
   } bounds_type;

   typedef struct packed {
      logic beyond;
      logic fit;
   } unit_stat_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_SEED,
      OP_SUM,
      OP_MERGE,
      OP_TEST
   } unit_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_FIND,
      ST_SEED_LOAD,
      ST_CAND_FIND,
      ST_CAND_SUM,
      ST_CAND_MERGE,
      ST_CAND_TEST,
      ST_CLOSE,
      ST_FLUSH
   } seq_state_type;

endpackage

`default_nettype wire

// File: rtl/rpwc_if.sv
// ----------------------------------------------------------------------------
// rpwc_if
// Valid/ready channels for read pairs in and clusters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpwc_req_if;
   import rpwc_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] first_pos;
   logic [LEN_W-1:0] first_len;
   logic [POS_W-1:0] second_pos;
   logic [LEN_W-1:0] second_len;
   logic             last_pair;

   modport source (
      output valid, first_pos, first_len, second_pos, second_len, last_pair,
      input  ready
   );
   modport sink (
      input  valid, first_pos, first_len, second_pos, second_len, last_pair,
      output ready
   );
endinterface

interface rpwc_rsp_if;
   import rpwc_pkg::*;

   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    start_one;
   logic [POS_W-1:0]    end_one;
   logic [POS_W-1:0]    start_two;
   logic [POS_W-1:0]    end_two;
   logic [MEMBER_W-1:0] member_count;
   logic [SEED_W-1:0]   seed_index;
   logic                last_cluster;

   modport source (
      output valid, start_one, end_one, start_two, end_two, member_count,
             seed_index, last_cluster,
      input  ready
   );
   modport sink (
      input  valid, start_one, end_one, start_two, end_two, member_count,
             seed_index, last_cluster,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/rpwc_pair_mem.sv
// ----------------------------------------------------------------------------
// rpwc_pair_mem
// Pair store, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwc_pair_mem
   import rpwc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire pair_type         wr_data,
   input  wire logic [IDX_W-1:0] rd_addr,
   output pair_type              rd_data
);

   pair_type mem [MAX_PAIRS];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rpwc_unit.sv
// ----------------------------------------------------------------------------
// rpwc_unit
// Shared datapath: seed bounds, candidate ends, merge and window test.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwc_unit
   import rpwc_pkg::*;
(
   input  wire logic             clock,
   input  wire unit_op_type      op,
   input  wire pair_type         pair,
   input  wire logic [WIN_W-1:0] window,
   output bounds_type            bounds,
   output unit_stat_type         stat
);

   logic [POS_W-1:0] s1_ff, s1_in;
   logic [POS_W-1:0] e1_ff, e1_in;
   logic [POS_W-1:0] s2_ff, s2_in;
   logic [POS_W-1:0] e2_ff, e2_in;
   logic [POS_W-1:0] reach_ff, reach_in;
   logic [POS_W-1:0] c1_ff, c1_in;
   logic [POS_W-1:0] c2_ff, c2_in;
   logic [POS_W-1:0] c3_ff, c3_in;
   logic             beyond_ff, beyond_in;

   logic [POS_W-1:0] span_one;
   logic [POS_W-1:0] span_two;
   logic [POS_W-1:0] window_ext;
   logic             fit;

   assign window_ext = POS_W'(window);
   assign span_one   = c1_ff - s1_ff;
   assign span_two   = c3_ff - c2_ff;
   assign fit        = (span_one <= window_ext) && (span_two <= window_ext);

   always_comb begin
      s1_in     = s1_ff;
      e1_in     = e1_ff;
      s2_in     = s2_ff;
      e2_in     = e2_ff;
      reach_in  = reach_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      c3_in     = c3_ff;
      beyond_in = beyond_ff;
      unique case (op)
         OP_IDLE: begin
         end
         OP_SEED: begin
            // reach is seed start plus twice the window
            s1_in    = pair.first_pos + POS_W'(1);
            e1_in    = pair.first_pos + POS_W'(pair.first_len);
            s2_in    = pair.second_pos + POS_W'(1);
            e2_in    = pair.second_pos + POS_W'(pair.second_len);
            reach_in = pair.first_pos + POS_W'({window, 1'b1});
         end
         OP_SUM: begin
            c1_in     = pair.first_pos + POS_W'(pair.first_len);
            c2_in     = pair.second_pos + POS_W'(1);
            c3_in     = pair.second_pos + POS_W'(pair.second_len);
            beyond_in = pair.first_pos > reach_ff;
         end
         OP_MERGE: begin
            c1_in = (c1_ff > e1_ff) ? c1_ff : e1_ff;
            c2_in = (c2_ff < s2_ff) ? c2_ff : s2_ff;
            c3_in = (c3_ff > e2_ff) ? c3_ff : e2_ff;
         end
         OP_TEST: begin
            if (fit) begin
               e1_in = c1_ff;
               s2_in = c2_ff;
               e2_in = c3_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s1_ff     <= s1_in;
      e1_ff     <= e1_in;
      s2_ff     <= s2_in;
      e2_ff     <= e2_in;
      reach_ff  <= reach_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      c3_ff     <= c3_in;
      beyond_ff <= beyond_in;
   end

   assign bounds.start_one = s1_ff;
   assign bounds.end_one   = e1_ff;
   assign bounds.start_two = s2_ff;
   assign bounds.end_two   = e2_ff;
   assign stat.beyond      = beyond_ff;
   assign stat.fit         = fit;

endmodule

`default_nettype wire

// File: rtl/rpwc_sequencer.sv
// ----------------------------------------------------------------------------
// rpwc_sequencer
// Load counter, taken flags, clustering scan control and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpwc_sequencer
   import rpwc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last,
   output logic                   req_ready,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output result_type             rsp_data,
   input  wire logic [MINP_W-1:0] min_pairs,
   output logic                   mem_wr_en,
   output logic [IDX_W-1:0]       mem_wr_addr,
   output logic [IDX_W-1:0]       mem_rd_addr,
   output unit_op_type            op,
   input  wire bounds_type        bounds,
   input  wire unit_stat_type     stat
);

   seq_state_type          state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       seed_ff, seed_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]       members_ff, members_in;
   logic [MAX_PAIRS-1:0]   taken_ff, taken_in;
   logic                   pend_valid_ff, pend_valid_in;
   result_type             pend_ff, pend_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;

   logic             store_ok;
   logic [CNT_W-1:0] count_next;
   logic             seed_end;
   logic             seed_taken;
   logic             k_end;
   logic             k_taken;
   logic             emit_ok;
   logic             out_free;
   logic             close_stall;
   logic             flush_stall;

   assign store_ok    = count_ff < CNT_W'(MAX_PAIRS);
   assign count_next  = count_ff + CNT_W'(store_ok);
   assign seed_end    = (n_ff < CNT_W'(2)) || (seed_ff >= n_ff);
   assign seed_taken  = taken_ff[seed_ff[IDX_W-1:0]];
   assign k_end       = k_ff >= n_ff;
   assign k_taken     = taken_ff[k_ff[IDX_W-1:0]];
   assign emit_ok     = CMP_W'(members_ff) >= CMP_W'(min_pairs);
   assign out_free    = !out_valid_ff || rsp_ready;
   assign close_stall = emit_ok && pend_valid_ff && !out_free;
   assign flush_stall = pend_valid_ff && !out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last) begin
               state_in = ST_SEED_FIND;
            end
         end
         ST_SEED_FIND: begin
            if (seed_end) begin
               state_in = ST_FLUSH;
            end else if (!seed_taken) begin
               state_in = ST_SEED_LOAD;
            end
         end
         ST_SEED_LOAD: state_in = ST_CAND_FIND;
         ST_CAND_FIND: begin
            if (k_end) begin
               state_in = ST_CLOSE;
            end else if (!k_taken) begin
               state_in = ST_CAND_SUM;
            end
         end
         ST_CAND_SUM: state_in = ST_CAND_MERGE;
         ST_CAND_MERGE: begin
            state_in = stat.beyond ? ST_CLOSE : ST_CAND_TEST;
         end
         ST_CAND_TEST: state_in = ST_CAND_FIND;
         ST_CLOSE: begin
            if (!close_stall) begin
               state_in = ST_SEED_FIND;
            end
         end
         ST_FLUSH: begin
            if (!flush_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath registers
   always_comb begin
      count_in      = count_ff;
      n_in          = n_ff;
      seed_in       = seed_ff;
      k_in          = k_ff;
      members_in    = members_ff;
      taken_in      = taken_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      req_ready     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[IDX_W-1:0];
      mem_rd_addr   = k_ff[IDX_W-1:0];
      op            = OP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mem_wr_en = store_ok;
               count_in  = count_next;
               if (req_last) begin
                  n_in    = count_next;
                  seed_in = '0;
               end
            end
         end
         ST_SEED_FIND: begin
            mem_rd_addr = seed_ff[IDX_W-1:0];
            if (!seed_end) begin
               if (seed_taken) begin
                  seed_in = seed_ff + CNT_W'(1);
               end else begin
                  taken_in[seed_ff[IDX_W-1:0]] = 1'b1;
                  members_in                   = CNT_W'(1);
                  k_in                         = seed_ff + CNT_W'(1);
               end
            end
         end
         ST_SEED_LOAD: op = OP_SEED;
         ST_CAND_FIND: begin
            if (!k_end && k_taken) begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         ST_CAND_SUM:   op = OP_SUM;
         ST_CAND_MERGE: op = OP_MERGE;
         ST_CAND_TEST: begin
            op   = OP_TEST;
            k_in = k_ff + CNT_W'(1);
            if (stat.fit) begin
               taken_in[k_ff[IDX_W-1:0]] = 1'b1;
               members_in                = members_ff + CNT_W'(1);
            end
         end
         ST_CLOSE: begin
            // a cluster waits in the pending slot until the next one shows it is not last
            if (!close_stall) begin
               seed_in = seed_ff + CNT_W'(1);
               if (emit_ok) begin
                  pend_valid_in        = 1'b1;
                  pend_in.start_one    = bounds.start_one;
                  pend_in.end_one      = bounds.end_one;
                  pend_in.start_two    = bounds.start_two;
                  pend_in.end_two      = bounds.end_two;
                  pend_in.member_count = MEMBER_W'(members_ff);
                  pend_in.seed_index   = SEED_W'(seed_ff);
                  pend_in.last_cluster = 1'b0;
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = pend_ff;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!flush_stall) begin
               count_in      = '0;
               taken_in      = '0;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  out_valid_in        = 1'b1;
                  out_in              = pend_ff;
                  out_in.last_cluster = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         taken_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         taken_ff      <= taken_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      seed_ff    <= seed_in;
      k_ff       <= k_in;
      members_ff <= members_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// File: rtl/read_pair_window_clustering_unit.sv
// ----------------------------------------------------------------------------
// read_pair_window_clustering_unit
// Stores sorted read pairs and greedily clusters them on the last pair.
// ----------------------------------------------------------------------------
//  channel   direction   handshake            payload
//  req_if    in          valid/ready          one read pair, last_pair flag
//  rsp_if    out         valid/ready          one cluster, last_cluster flag
//  csr_*     in          write enable only    cluster_window, min_pairs
//
//  a pair is taken while the unit is idle; on last_pair the scan runs with
//  ready low: taken indices are skipped, each seed is loaded, each candidate
//  is summed, merged and tested (a stop beyond the reach skips the test),
//  each seed is closed and a flush finishes, one memory read per step
//  synchronous reset clears control state; the pair memory is never cleared
//  a result waiting at rsp_if holds the scan only when another cluster is due
// ----------------------------------------------------------------------------
`default_nettype none

module read_pair_window_clustering_unit
   import rpwc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   rpwc_req_if.sink                   req_if,
   rpwc_rsp_if.source                 rsp_if,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [WIN_W-1:0]  cluster_window_ff, cluster_window_in;
   logic [MINP_W-1:0] min_pairs_ff, min_pairs_in;

   pair_type      wr_pair;
   pair_type      rd_pair;
   logic          mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [IDX_W-1:0] mem_rd_addr;
   unit_op_type   op;
   bounds_type    bounds;
   unit_stat_type stat;
   result_type    rsp_data;

   always_comb begin
      cluster_window_in = cluster_window_ff;
      min_pairs_in      = min_pairs_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_CLUSTER_WINDOW) begin
            cluster_window_in = csr_wr_data;
         end
         if (csr_index == CSR_MIN_PAIRS) begin
            min_pairs_in = csr_wr_data[MINP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_window_ff <= WINDOW_RESET;
         min_pairs_ff      <= MIN_PAIRS_RESET;
      end else begin
         cluster_window_ff <= cluster_window_in;
         min_pairs_ff      <= min_pairs_in;
      end
   end

   assign wr_pair.first_pos  = req_if.first_pos;
   assign wr_pair.first_len  = req_if.first_len;
   assign wr_pair.second_pos = req_if.second_pos;
   assign wr_pair.second_len = req_if.second_len;

   rpwc_pair_mem u_pair_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (wr_pair),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_pair)
   );

   rpwc_unit u_unit (
      .clock  (clock),
      .op     (op),
      .pair   (rd_pair),
      .window (cluster_window_ff),
      .bounds (bounds),
      .stat   (stat)
   );

   rpwc_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_last    (req_if.last_pair),
      .req_ready   (req_if.ready),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_data    (rsp_data),
      .min_pairs   (min_pairs_ff),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_addr (mem_rd_addr),
      .op          (op),
      .bounds      (bounds),
      .stat        (stat)
   );

   assign rsp_if.start_one    = rsp_data.start_one;
   assign rsp_if.end_one      = rsp_data.end_one;
   assign rsp_if.start_two    = rsp_data.start_two;
   assign rsp_if.end_two      = rsp_data.end_two;
   assign rsp_if.member_count = rsp_data.member_count;
   assign rsp_if.seed_index   = rsp_data.seed_index;
   assign rsp_if.last_cluster = rsp_data.last_cluster;

`ifndef SYNTHESIS
   // a last pair starts the scan, so no pair is taken the cycle after
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.last_pair) |=> !req_if.ready)
      else $error("input taken while clustering runs");

   // every cluster has at least its seed
   a_members_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.member_count != '0))
      else $error("cluster without members");

   // a waiting cluster stays put until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && $stable(rsp_data)))
      else $error("cluster changed while waiting");
`endif

endmodule

`default_nettype wire
